// ===== rtl/rpcp_pkg.sv =====
// ----------------------------------------------------------------------------
// rpcp_pkg
// Types and codes shared by the request payload parser front, queue and back.
// ----------------------------------------------------------------------------
package rpcp_pkg;

  // result kinds
  localparam logic [1:0] KIND_ARG_BYTE  = 2'd0;
  localparam logic [1:0] KIND_ARG_EMPTY = 2'd1;
  localparam logic [1:0] KIND_VERDICT   = 2'd2;

  // verdict codes
  localparam logic [1:0] VERDICT_OK        = 2'd0;
  localparam logic [1:0] VERDICT_MALFORMED = 2'd1;
  localparam logic [1:0] VERDICT_BAD_ARGS  = 2'd2;

  // header is id low, id high, count, reserved
  localparam logic [1:0] HDR_LAST_POS = 2'd3;

  // queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // one input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_payload;
    logic       empty_payload;
  } in_t;

  // one result request
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  arg_slot;
    logic [4:0]  byte_pos;
    logic [7:0]  byte_value;
    logic        arg_end;
    logic [5:0]  arg_length;
    logic [1:0]  verdict;
    logic [15:0] rpc_id;
    logic [7:0]  arg_count;
    logic        last;
  } out_t;

  // classified input: an optional argument result and an optional verdict
  typedef struct packed {
    logic        has_arg;
    logic        arg_empty;
    logic [1:0]  arg_slot;
    logic [4:0]  byte_pos;
    logic [7:0]  byte_value;
    logic        arg_end;
    logic [5:0]  arg_length;
    logic        has_verdict;
    logic [1:0]  verdict;
    logic [15:0] rpc_id;
    logic [7:0]  arg_count;
  } rec_t;

endpackage

// ===== rtl/rpcp_front.sv =====
// ----------------------------------------------------------------------------
// rpcp_front
// Payload parser state machine: takes one byte request per cycle while accept_i
// is high and turns it into a record of the results it causes.
// ----------------------------------------------------------------------------
module rpcp_front #(
  parameter int unsigned MAX_ARG_SLOTS = 4,
  parameter int unsigned MAX_ARG_BYTES = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  rpcp_pkg::in_t in_i,
  output logic          push_o,
  output rpcp_pkg::rec_t rec_o
);
  import rpcp_pkg::*;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_ARGLEN  = 3'd1;
  localparam logic [2:0] PH_ARGDATA = 3'd2;
  localparam logic [2:0] PH_TRAIL   = 3'd3;
  localparam logic [2:0] PH_ERROR   = 3'd4;

  localparam logic [7:0] SLOTS_LIM = 8'(MAX_ARG_SLOTS);
  localparam logic [7:0] BYTES_LIM = 8'(MAX_ARG_BYTES);

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  hdr_pos_q, hdr_pos_d;
  logic [15:0] id_q, id_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  seen_q, seen_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  left_q, left_d;
  logic        bad_q, bad_d;
  logic        malf_q, malf_d;

  logic [7:0]  b;
  logic [7:0]  pos;
  logic        short_hdr;
  rec_t        rec;

  assign b   = in_i.data_byte;
  assign pos = len_q - left_q;

  // parse step
  always_comb begin
    phase_d   = phase_q;
    hdr_pos_d = hdr_pos_q;
    id_d      = id_q;
    count_d   = count_q;
    seen_d    = seen_q;
    len_d     = len_q;
    left_d    = left_q;
    bad_d     = bad_q;
    malf_d    = malf_q;
    short_hdr = 1'b0;
    rec       = '0;

    if (!in_i.empty_payload) begin
      unique case (phase_q)
        PH_HEADER: begin
          unique case (hdr_pos_q)
            2'd0:    id_d[7:0]  = b;
            2'd1:    id_d[15:8] = b;
            2'd2:    count_d    = b;
            default: ;
          endcase
          if (hdr_pos_q == HDR_LAST_POS) begin
            hdr_pos_d = '0;
            if (b != 8'd0) begin
              malf_d  = 1'b1;
              phase_d = PH_ERROR;
            end else begin
              if (count_q > SLOTS_LIM) bad_d = 1'b1;
              phase_d = (count_q == 8'd0) ? PH_TRAIL : PH_ARGLEN;
            end
          end else begin
            hdr_pos_d = hdr_pos_q + 2'd1;
          end
        end
        PH_ARGLEN: begin
          len_d  = b;
          left_d = b;
          if (b > BYTES_LIM) bad_d = 1'b1;
          if (b == 8'd0) begin
            // zero-length argument completes at once
            if (seen_q < SLOTS_LIM) begin
              rec.has_arg   = 1'b1;
              rec.arg_empty = 1'b1;
              rec.arg_slot  = seen_q[1:0];
              rec.arg_end   = 1'b1;
            end
            seen_d  = seen_q + 8'd1;
            phase_d = (seen_d >= count_q) ? PH_TRAIL : PH_ARGLEN;
          end else begin
            phase_d = PH_ARGDATA;
          end
        end
        PH_ARGDATA: begin
          if (b == 8'd0) bad_d = 1'b1;
          if ((seen_q < SLOTS_LIM) && (len_q <= BYTES_LIM)) begin
            rec.has_arg    = 1'b1;
            rec.arg_slot   = seen_q[1:0];
            rec.byte_pos   = pos[4:0];
            rec.byte_value = b;
            rec.arg_end    = (left_q == 8'd1);
            rec.arg_length = len_q[5:0];
          end
          left_d = left_q - 8'd1;
          if (left_q == 8'd1) begin
            seen_d  = seen_q + 8'd1;
            phase_d = (seen_d >= count_q) ? PH_TRAIL : PH_ARGLEN;
          end
        end
        PH_TRAIL: begin
          malf_d  = 1'b1;
          phase_d = PH_ERROR;
        end
        default: ;
      endcase
    end

    rec.rpc_id    = id_d;
    rec.arg_count = count_d;

    // end of payload: verdict, then back to reset state
    if (in_i.end_of_payload) begin
      short_hdr = (phase_d == PH_HEADER);
      if ((phase_d == PH_HEADER) || (phase_d == PH_ARGLEN) || (phase_d == PH_ARGDATA)) begin
        malf_d = 1'b1;
      end
      rec.has_verdict = 1'b1;
      rec.verdict     = malf_d ? VERDICT_MALFORMED : (bad_d ? VERDICT_BAD_ARGS : VERDICT_OK);
      if (short_hdr) begin
        rec.rpc_id    = '0;
        rec.arg_count = '0;
      end
      phase_d   = PH_HEADER;
      hdr_pos_d = '0;
      id_d      = '0;
      count_d   = '0;
      seen_d    = '0;
      len_d     = '0;
      left_d    = '0;
      bad_d     = 1'b0;
      malf_d    = 1'b0;
    end
  end

  assign rec_o  = rec;
  assign push_o = accept_i && (rec.has_arg || rec.has_verdict);

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hdr_pos_q <= '0;
      id_q      <= '0;
      count_q   <= '0;
      seen_q    <= '0;
      len_q     <= '0;
      left_q    <= '0;
      bad_q     <= 1'b0;
      malf_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      hdr_pos_q <= hdr_pos_d;
      id_q      <= id_d;
      count_q   <= count_d;
      seen_q    <= seen_d;
      len_q     <= len_d;
      left_q    <= left_d;
      bad_q     <= bad_d;
      malf_q    <= malf_d;
    end
  end

endmodule

// ===== rtl/rpcp_queue.sv =====
// ----------------------------------------------------------------------------
// rpcp_queue
// Small record FIFO that decouples the parser from the result stage.
// ----------------------------------------------------------------------------
module rpcp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rpcp_pkg::rec_t push_rec_i,
  input  logic           pop_i,
  output rpcp_pkg::rec_t head_rec_o,
  output logic           empty_o,
  output logic           full_o
);
  import rpcp_pkg::*;

  rec_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign empty_o    = (cnt_q == '0);
  assign full_o     = (cnt_q == QCNT_W'(QDEPTH));
  assign head_rec_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_rec_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/rpcp_back.sv =====
// ----------------------------------------------------------------------------
// rpcp_back
// Result stage: expands each record into one or two result requests and
// holds them in an output register.
// ----------------------------------------------------------------------------
module rpcp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rpcp_pkg::rec_t head_rec_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rpcp_pkg::out_t out_data_o
);
  import rpcp_pkg::*;

  logic out_valid_q;
  out_t out_q, out_d;
  logic half_q, half_d;
  logic load;
  logic send_verdict;

  assign load = !empty_i && (!out_valid_q || out_ready_i);

  // pick argument or verdict half of the head record
  always_comb begin
    send_verdict = half_q || !head_rec_i.has_arg;
    out_d        = '0;
    half_d       = half_q;
    pop_o        = 1'b0;
    out_d.rpc_id    = head_rec_i.rpc_id;
    out_d.arg_count = head_rec_i.arg_count;
    if (send_verdict) begin
      out_d.kind    = KIND_VERDICT;
      out_d.verdict = head_rec_i.verdict;
      out_d.last    = 1'b1;
    end else begin
      out_d.kind       = head_rec_i.arg_empty ? KIND_ARG_EMPTY : KIND_ARG_BYTE;
      out_d.arg_slot   = head_rec_i.arg_slot;
      out_d.byte_pos   = head_rec_i.byte_pos;
      out_d.byte_value = head_rec_i.byte_value;
      out_d.arg_end    = head_rec_i.arg_end;
      out_d.arg_length = head_rec_i.arg_length;
      out_d.last       = !head_rec_i.has_verdict;
    end
    if (load) begin
      if (!send_verdict && head_rec_i.has_verdict) begin
        half_d = 1'b1;
      end else begin
        half_d = 1'b0;
        pop_o  = 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      half_q      <= 1'b0;
    end else begin
      half_q <= half_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/rpc_request_payload_parser.sv =====
// ----------------------------------------------------------------------------
// rpc_request_payload_parser
// Parses request payloads one byte per request; emits argument bytes and a
// verdict per payload.
// ----------------------------------------------------------------------------
// Path: accepted requests go through the record queue and the output register.
// Throughput: one input request per cycle while the record queue is not full;
//   an input that yields both an argument result and its verdict is sent as
//   two results by the single output register; the 4-entry record queue absorbs such bursts.
// Reset: rst_ni clears the parser state, the queue and the output valid.
module rpc_request_payload_parser #(
  parameter int unsigned MAX_ARG_SLOTS = 4,
  parameter int unsigned MAX_ARG_BYTES = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rpcp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rpcp_pkg::out_t out_data_o
);
  import rpcp_pkg::*;

  logic accept;
  logic push, pop, q_empty, q_full;
  rec_t push_rec, head_rec;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && !q_full;

  // front: parse and classify
  rpcp_front #(
    .MAX_ARG_SLOTS(MAX_ARG_SLOTS),
    .MAX_ARG_BYTES(MAX_ARG_BYTES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .in_i    (in_data_i),
    .push_o  (push),
    .rec_o   (push_rec)
  );

  // record queue
  rpcp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_rec_i(push_rec),
    .pop_i     (pop),
    .head_rec_o(head_rec),
    .empty_o   (q_empty),
    .full_o    (q_full)
  );

  // back: result expansion
  rpcp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_rec_i (head_rec),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
